/* src/esc_pkg.sv */
// Shared types and constants for the environmental sensor compensation pipeline.
// No dependencies; imported by every module of the block.
package esc_pkg;

    localparam int TF_W     = 25;
    localparam int N_MAG_W  = 75;
    localparam int D_MAG_W  = 40;
    localparam int QUOT_W   = 37;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [QUOT_W-1:0] PRESS_LIM = QUOT_W'(1) << 35;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP    = 3'd0,
        REG_PRESS_A = 3'd1,
        REG_PRESS_B = 3'd2,
        REG_PRESS_C = 3'd3,
        REG_HUM     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } coeff_t;

    typedef struct packed {
        logic signed [14:0]     temp;
        logic signed [TF_W-1:0] tf;
        logic        [15:0]     adh;
    } side_t;

    typedef struct packed {
        logic signed [14:0]     temp;
        logic signed [TF_W-1:0] tf;
        logic        [19:0]     adp;
        logic        [15:0]     adh;
    } temp_out_t;

    typedef struct packed {
        logic [N_MAG_W-1:0] nmag;
        logic [D_MAG_W-1:0] dmag;
        logic               neg;
        logic               inv;
        side_t              side;
    } div_in_t;

    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              ovf;
        logic              neg;
        logic              inv;
        side_t             side;
    } div_out_t;

    typedef struct packed {
        logic signed [14:0] temp;
        logic        [16:0] pa;
        logic               inv;
        logic        [13:0] hum;
    } res_t;

endpackage

/* src/esc_temp.sv */
// Temperature stages: fine temperature tf and centidegree result, five stages.
// Depends on esc_pkg.
module esc_temp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [19:0]        raw_t,
    input  logic [19:0]        raw_p,
    input  logic [15:0]        raw_h,
    input  esc_pkg::coeff_t    coef,
    output logic               out_valid,
    output esc_pkg::temp_out_t out_data
);
    import esc_pkg::*;

    localparam int Stages = 5;

    logic [Stages-1:0] vld_reg;
    logic [19:0] adp_reg [Stages];
    logic [15:0] adh_reg [Stages];

    logic signed [17:0] a_reg, a_next;
    logic signed [16:0] b_reg, b_next;
    logic signed [33:0] m1_reg, m1_next;
    logic signed [33:0] bb_reg, bb_next;
    logic signed [22:0] m1s_reg, m1s_next;
    logic signed [37:0] t3_reg, t3_next;
    logic signed [TF_W-1:0] tf_reg, tf_next;
    logic signed [TF_W-1:0] tf5_reg;
    logic signed [14:0] temp_reg, temp_next;
    logic signed [27:0] tm;
    logic signed [19:0] tsh;

    always_comb
    begin
        a_next   = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
        b_next   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coef.t1});
        m1_next  = a_reg * $signed(coef.t2);
        bb_next  = b_reg * b_reg;
        m1s_next = 23'(m1_reg >>> 11);
        t3_next  = $signed(bb_reg[33:12]) * $signed(coef.t3);
        tf_next  = TF_W'(m1s_reg + TF_W'(t3_reg >>> 14));
        tm       = 28'(tf_reg) * 28'sd5 + 28'sd128;
        tsh      = 20'(tm >>> 8);
        if (tsh > 20'sd16383)
        begin
            temp_next = 15'sd16383;
        end
        else if (tsh < -20'sd8192)
        begin
            temp_next = -15'sd8192;
        end
        else
        begin
            temp_next = 15'(tsh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            m1_reg   <= m1_next;
            bb_reg   <= bb_next;
            m1s_reg  <= m1s_next;
            t3_reg   <= t3_next;
            tf_reg   <= tf_next;
            tf5_reg  <= tf_reg;
            temp_reg <= temp_next;
            adp_reg[0] <= raw_p;
            adh_reg[0] <= raw_h;
            for (int i = 1; i < Stages; i++)
            begin
                adp_reg[i] <= adp_reg[i-1];
                adh_reg[i] <= adh_reg[i-1];
            end
        end
    end

    assign out_valid     = vld_reg[Stages-1];
    assign out_data.temp = temp_reg;
    assign out_data.tf   = tf5_reg;
    assign out_data.adp  = adp_reg[Stages-1];
    assign out_data.adh  = adh_reg[Stages-1];

endmodule

/* src/esc_prep.sv */
// Pressure operand stages: numerator and divisor magnitudes for the divider, seven stages.
// Depends on esc_pkg.
module esc_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  esc_pkg::temp_out_t in_data,
    input  esc_pkg::coeff_t    coef,
    output logic               out_valid,
    output esc_pkg::div_in_t   out_data
);
    import esc_pkg::*;

    localparam int Stages = 7;

    logic [Stages-1:0] vld_reg;
    side_t side_reg [Stages-1];
    logic [19:0] adp_reg [3];

    logic signed [TF_W-1:0] x_reg, x_next;
    logic signed [49:0] xx_reg, xx_next;
    logic signed [40:0] xp5_reg, xp5_next, xp5_d_reg;
    logic signed [40:0] xp2_reg, xp2_next, xp2_d_reg;
    logic signed [65:0] w2a_reg, w2a_next;
    logic signed [65:0] w1a_reg, w1a_next;
    logic signed [65:0] w2_reg, w2_next;
    logic signed [55:0] v_reg, v_next;
    logic        [51:0] tp_reg, tp_next;
    logic signed [72:0] vp_reg, vp_next;
    logic signed [63:0] n_reg, n_next;
    logic signed [D_MAG_W-1:0] w1_reg, w1_next;
    logic signed [76:0] nn_reg, nn_next;
    div_in_t dout_reg, dout_next;

    always_comb
    begin
        x_next   = in_data.tf - TF_W'(128000);
        xx_next  = x_reg * x_reg;
        xp5_next = x_reg * $signed(coef.p5);
        xp2_next = x_reg * $signed(coef.p2);
        w2a_next = xx_reg * $signed(coef.p6);
        w1a_next = xx_reg * $signed(coef.p3);
        w2_next  = w2a_reg + (66'(xp5_d_reg) <<< 17) + (66'($signed(coef.p4)) <<< 35);
        v_next   = 56'((w1a_reg >>> 8) + (66'(xp2_d_reg) <<< 12) + (66'sd1 <<< 47));
        tp_next  = {21'd1048576 - {1'b0, adp_reg[2]}, 31'd0};
        vp_next  = v_reg * $signed({1'b0, coef.p1});
        n_next   = 64'($signed({1'b0, tp_reg}) - w2_reg);
        w1_next  = D_MAG_W'(vp_reg >>> 33);
        nn_next  = n_reg * 13'sd3125;
        dout_next.nmag = N_MAG_W'(nn_reg[76] ? -nn_reg : nn_reg);
        dout_next.dmag = D_MAG_W'(w1_reg[D_MAG_W-1] ? -w1_reg : w1_reg);
        dout_next.neg  = nn_reg[76] ^ w1_reg[D_MAG_W-1];
        dout_next.inv  = (w1_reg == '0);
        dout_next.side = side_reg[Stages-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            xx_reg    <= xx_next;
            xp5_reg   <= xp5_next;
            xp2_reg   <= xp2_next;
            w2a_reg   <= w2a_next;
            w1a_reg   <= w1a_next;
            xp5_d_reg <= xp5_reg;
            xp2_d_reg <= xp2_reg;
            w2_reg    <= w2_next;
            v_reg     <= v_next;
            tp_reg    <= tp_next;
            vp_reg    <= vp_next;
            n_reg     <= n_next;
            w1_reg    <= w1_next;
            nn_reg    <= nn_next;
            dout_reg  <= dout_next;
            side_reg[0].temp <= in_data.temp;
            side_reg[0].tf   <= in_data.tf;
            side_reg[0].adh  <= in_data.adh;
            for (int i = 1; i < Stages - 1; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            adp_reg[0] <= in_data.adp;
            adp_reg[1] <= adp_reg[0];
            adp_reg[2] <= adp_reg[1];
        end
    end

    assign out_valid = vld_reg[Stages-1];
    assign out_data  = dout_reg;

endmodule

/* src/esc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with quotient overflow flag.
// Depends on esc_pkg.
module esc_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  esc_pkg::div_in_t  in_data,
    output logic              out_valid,
    output esc_pkg::div_out_t out_data
);
    import esc_pkg::*;

    localparam int QW = QUOT_W;
    localparam int DW = D_MAG_W;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] nq;
        logic [DW-1:0] dmag;
        logic          ovf;
        logic          neg;
        logic          inv;
        side_t         side;
    } step_t;

    function automatic step_t div_step(input step_t s);
        logic [DW:0] trial;
        logic [DW:0] diff;
        step_t       o;
        trial = {s.rem, s.nq[QW-1]};
        diff  = trial - {1'b0, s.dmag};
        o     = s;
        if (trial >= {1'b0, s.dmag})
        begin
            o.rem = diff[DW-1:0];
            o.nq  = {s.nq[QW-2:0], 1'b1};
        end
        else
        begin
            o.rem = trial[DW-1:0];
            o.nq  = {s.nq[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [QW:0] vld_reg;
    step_t st_reg [QW+1];
    step_t st0_next;

    always_comb
    begin
        st0_next.rem  = DW'(in_data.nmag[N_MAG_W-1:QW]);
        st0_next.nq   = in_data.nmag[QW-1:0];
        st0_next.dmag = in_data.dmag;
        st0_next.ovf  = DW'(in_data.nmag[N_MAG_W-1:QW]) >= in_data.dmag;
        st0_next.neg  = in_data.neg;
        st0_next.inv  = in_data.inv;
        st0_next.side = in_data.side;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
            for (int k = 0; k < QW; k++)
            begin
                st_reg[k+1] <= div_step(st_reg[k]);
            end
        end
    end

    assign out_valid     = vld_reg[QW];
    assign out_data.quot = st_reg[QW].nq;
    assign out_data.ovf  = st_reg[QW].ovf;
    assign out_data.neg  = st_reg[QW].neg;
    assign out_data.inv  = st_reg[QW].inv;
    assign out_data.side = st_reg[QW].side;

endmodule

/* src/esc_back.sv */
// Output stages: pressure second-order correction and humidity compensation, twelve stages.
// Depends on esc_pkg.
module esc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  esc_pkg::div_out_t in_data,
    input  esc_pkg::coeff_t   coef,
    output logic              out_valid,
    output esc_pkg::res_t     out_data
);
    import esc_pkg::*;

    localparam int Stages = 12;
    localparam int PaStages = 8;

    logic [Stages-1:0] vld_reg;
    logic              inv_reg  [Stages];
    logic signed [14:0] temp_reg [Stages];
    logic        [16:0] pa_reg  [PaStages];
    logic        [15:0] adh_reg [2];
    logic signed [23:0] a_reg   [5];

    // pressure
    logic        [QUOT_W-1:0] qc;
    logic signed [QUOT_W-1:0] p_reg, p_next, p_d1_reg, p_d2_reg;
    logic signed [23:0] s13;
    logic signed [47:0] ss_reg, ss_next;
    logic signed [52:0] p8p_reg, p8p_next, p8p_d_reg;
    logic signed [63:0] t9_reg, t9_next;
    logic signed [39:0] psum;
    logic signed [33:0] p2_reg, p2_next;
    logic signed [25:0] pq;
    logic        [16:0] pa_next;

    // humidity
    logic signed [TF_W-1:0] hv_reg, hv_next;
    logic signed [36:0] m5_reg, m5_next;
    logic signed [32:0] m6_reg, m6_next;
    logic signed [33:0] m3_reg, m3_next;
    logic signed [37:0] asum;
    logic signed [23:0] a_next;
    logic signed [22:0] bb1_reg, bb1_next;
    logic signed [23:0] bb2_reg, bb2_next;
    logic signed [46:0] bp_reg, bp_next;
    logic signed [37:0] b0_reg, b0_next;
    logic signed [53:0] b1_reg, b1_next;
    logic signed [39:0] bq_reg, bq_next;
    logic signed [63:0] hp_reg, hp_next, hp_d1_reg, hp_d2_reg;
    logic signed [48:0] hs;
    logic               hneg_reg, hneg_next, hneg_d_reg;
    logic               big_reg, big_next, big_d_reg;
    logic        [53:0] ss2_reg, ss2_next;
    logic        [54:0] t_reg, t_next;
    logic signed [63:0] hdiff, hsel;
    logic        [28:0] hv2_reg, hv2_next;
    logic        [13:0] hum_reg, hum_next;

    always_comb
    begin
        if (in_data.ovf || (in_data.quot > PRESS_LIM))
        begin
            qc = PRESS_LIM;
        end
        else
        begin
            qc = in_data.quot;
        end
        p_next   = in_data.neg ? -$signed(qc) : $signed(qc);
        s13      = 24'(p_reg >>> 13);
        ss_next  = s13 * s13;
        p8p_next = p_reg * $signed(coef.p8);
        t9_next  = ss_reg * $signed(coef.p9);
        psum     = 40'(p_d2_reg) + 40'(t9_reg >>> 25) + 40'(p8p_d_reg >>> 19);
        p2_next  = 34'((psum >>> 8) + (40'($signed(coef.p7)) <<< 4));
        pq       = 26'(p2_reg >>> 8);
        if (inv_reg[3] || pq < 26'sd0)
        begin
            pa_next = '0;
        end
        else if (pq > 26'sd131071)
        begin
            pa_next = 17'd131071;
        end
        else
        begin
            pa_next = 17'(pq);
        end

        hv_next  = in_data.side.tf - TF_W'(76800);
        m5_next  = hv_reg * $signed(coef.h5);
        m6_next  = hv_reg * $signed(coef.h6);
        m3_next  = hv_reg * $signed({1'b0, coef.h3});
        asum     = $signed({4'b0, adh_reg[1], 14'b0}) - (38'($signed(coef.h4)) <<< 20)
                   - 38'(m5_reg) + 38'sd16384;
        a_next   = 24'(asum >>> 15);
        bb1_next = 23'(m6_reg >>> 10);
        bb2_next = 24'((m3_reg >>> 11) + 34'sd32768);
        bp_next  = bb1_reg * bb2_reg;
        b0_next  = 38'(bp_reg >>> 10) + 38'sd2097152;
        b1_next  = b0_reg * $signed(coef.h2);
        bq_next  = 40'((b1_reg + 54'sd8192) >>> 14);
        hp_next  = a_reg[4] * bq_reg;
        hs        = 49'(hp_reg >>> 15);
        hneg_next = hp_reg[63];
        big_next  = hs >= 49'sd134217728;
        ss2_next  = hs[26:0] * hs[26:0];
        t_next    = ss2_reg[53:7] * coef.h1;
        hdiff     = hp_d2_reg - $signed({1'b0, t_reg[54:4]});
        if (hneg_d_reg)
        begin
            hsel = '0;
        end
        else if (big_d_reg)
        begin
            hsel = (coef.h1 != 8'd0) ? 64'sd0 : hp_d2_reg;
        end
        else
        begin
            hsel = hdiff;
        end
        if (hsel < 64'sd0)
        begin
            hv2_next = '0;
        end
        else if (hsel > 64'sd419430400)
        begin
            hv2_next = 29'd419430400;
        end
        else
        begin
            hv2_next = 29'(hsel);
        end
        hum_next = 14'(((hv2_reg >> 12) * 29'd100) >> 10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            ss_reg    <= ss_next;
            p8p_reg   <= p8p_next;
            p_d1_reg  <= p_reg;
            t9_reg    <= t9_next;
            p8p_d_reg <= p8p_reg;
            p_d2_reg  <= p_d1_reg;
            p2_reg    <= p2_next;
            pa_reg[0] <= pa_next;
            for (int i = 1; i < PaStages; i++)
            begin
                pa_reg[i] <= pa_reg[i-1];
            end
            inv_reg[0]  <= in_data.inv;
            temp_reg[0] <= in_data.side.temp;
            for (int i = 1; i < Stages; i++)
            begin
                inv_reg[i]  <= inv_reg[i-1];
                temp_reg[i] <= temp_reg[i-1];
            end

            hv_reg     <= hv_next;
            adh_reg[0] <= in_data.side.adh;
            adh_reg[1] <= adh_reg[0];
            m5_reg     <= m5_next;
            m6_reg     <= m6_next;
            m3_reg     <= m3_next;
            a_reg[0]   <= a_next;
            for (int i = 1; i < 5; i++)
            begin
                a_reg[i] <= a_reg[i-1];
            end
            bb1_reg    <= bb1_next;
            bb2_reg    <= bb2_next;
            bp_reg     <= bp_next;
            b0_reg     <= b0_next;
            b1_reg     <= b1_next;
            bq_reg     <= bq_next;
            hp_reg     <= hp_next;
            hp_d1_reg  <= hp_reg;
            hneg_reg   <= hneg_next;
            big_reg    <= big_next;
            ss2_reg    <= ss2_next;
            hp_d2_reg  <= hp_d1_reg;
            hneg_d_reg <= hneg_reg;
            big_d_reg  <= big_reg;
            t_reg      <= t_next;
            hv2_reg    <= hv2_next;
            hum_reg    <= hum_next;
        end
    end

    assign out_valid     = vld_reg[Stages-1];
    assign out_data.temp = temp_reg[Stages-1];
    assign out_data.pa   = pa_reg[PaStages-1];
    assign out_data.inv  = inv_reg[Stages-1];
    assign out_data.hum  = hum_reg;

endmodule

/* src/env_sensor_compensation.sv */
// Environmental sensor compensation top level: coefficient registers and the pipeline.
// Depends on esc_pkg, esc_temp, esc_prep, esc_divider, esc_back.
// Pipeline stages in order: 5 temperature, 7 pressure operand, 38 divider, 12 output stages.
// One beat per cycle unless stalled; each of 37 divider step stages resolves one quotient bit.
// The whole pipeline holds while a result beat is stalled at the output register.
// Reset clears all coefficient registers and every stage valid bit at once.
module env_sensor_compensation (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [esc_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [esc_pkg::CFG_W-1:0]        wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [19:0]                      raw_temperature,
    input  logic [19:0]                      raw_pressure,
    input  logic [15:0]                      raw_humidity,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [14:0]               temperature_centi,
    output logic [16:0]                      pressure_pascal,
    output logic                             pressure_invalid,
    output logic [13:0]                      humidity_centi
);
    import esc_pkg::*;

    logic [47:0] temp_coeffs_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [47:0] press_c_reg;
    logic [63:0] hum_coeffs_reg;

    coeff_t    coef;
    logic      en;
    logic      temp_valid, prep_valid, div_valid;
    temp_out_t temp_data;
    div_in_t   prep_data;
    div_out_t  div_data;
    res_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_c_reg     <= '0;
            hum_coeffs_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TEMP:    temp_coeffs_reg <= wr_data[47:0];
                REG_PRESS_A: press_a_reg     <= wr_data[47:0];
                REG_PRESS_B: press_b_reg     <= wr_data[47:0];
                REG_PRESS_C: press_c_reg     <= wr_data[47:0];
                REG_HUM:     hum_coeffs_reg  <= wr_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        coef.t1 = temp_coeffs_reg[15:0];
        coef.t2 = $signed(temp_coeffs_reg[31:16]);
        coef.t3 = $signed(temp_coeffs_reg[47:32]);
        coef.p1 = press_a_reg[15:0];
        coef.p2 = $signed(press_a_reg[31:16]);
        coef.p3 = $signed(press_a_reg[47:32]);
        coef.p4 = $signed(press_b_reg[15:0]);
        coef.p5 = $signed(press_b_reg[31:16]);
        coef.p6 = $signed(press_b_reg[47:32]);
        coef.p7 = $signed(press_c_reg[15:0]);
        coef.p8 = $signed(press_c_reg[31:16]);
        coef.p9 = $signed(press_c_reg[47:32]);
        coef.h1 = hum_coeffs_reg[7:0];
        coef.h2 = $signed(hum_coeffs_reg[23:8]);
        coef.h3 = hum_coeffs_reg[31:24];
        coef.h4 = $signed(hum_coeffs_reg[43:32]);
        coef.h5 = $signed(hum_coeffs_reg[55:44]);
        coef.h6 = $signed(hum_coeffs_reg[63:56]);
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    esc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .raw_t     (raw_temperature),
        .raw_p     (raw_pressure),
        .raw_h     (raw_humidity),
        .coef      (coef),
        .out_valid (temp_valid),
        .out_data  (temp_data)
    );

    esc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (temp_valid),
        .in_data   (temp_data),
        .coef      (coef),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    esc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    esc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .coef      (coef),
        .out_valid (out_valid),
        .out_data  (res)
    );

    assign temperature_centi = res.temp;
    assign pressure_pascal   = res.pa;
    assign pressure_invalid  = res.inv;
    assign humidity_centi    = res.hum;

endmodule
